// File: sv/avc_config_record_to_start_codes_top_defines.svh
// Assertion helpers used by the avcs_emitter RTL.
`ifndef AVC_CONFIG_RECORD_TO_START_CODES_TOP_DEFINES_SVH
`define AVC_CONFIG_RECORD_TO_START_CODES_TOP_DEFINES_SVH

// Clocked check, off while reset is held.
`define AVCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check, also live during reset.
`define AVCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/avcs_pkg.sv
package avcs_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int TOTAL_W        = 20;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // register index (paddr[2])
  localparam logic REG_VERIFY_ONLY = 1'b0;

  localparam logic [7:0] RECORD_VERSION = 8'h01;
  localparam logic [7:0] RESERVED_MASK  = 8'hFC;
  localparam logic [7:0] SPS_CNT_MASK   = 8'h1F;
  localparam logic [7:0] LEN_SIZE_MASK  = 8'h03;
  localparam logic [2:0] HDR_LAST_IDX   = 3'd5;
  localparam logic [2:0] HDR_LEN_IDX    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_RECORD = 2'd1,
    ST_TRUNCATED  = 2'd2
  } avcs_status_t;

  // what one accepted byte produces
  typedef struct packed {
    logic                 start;
    logic                 pay;
    logic [7:0]           pay_byte;
    logic                 fin;
    avcs_status_t         status;
    logic [2:0]           lfs;
    logic [TOTAL_W-1:0]   total;
  } avcs_burst_t;

endpackage

// File: sv/avcs_in_if.sv
interface avcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: sv/avcs_out_if.sv
interface avcs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_end;
  logic [1:0]  status;
  logic [2:0]  length_field_size;
  logic [19:0] total_size;

  modport source (output valid, output out_byte, output is_end, output status,
                  output length_field_size, output total_size, input ready);
  modport sink   (input valid, input out_byte, input is_end, input status,
                  input length_field_size, input total_size, output ready);
endinterface

// File: sv/avcs_cfg_regs.sv
module avcs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [avcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [avcs_pkg::DATA_W-1:0]   pwdata,
  output logic [avcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic                          verify_only
);

  logic verify_only_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == avcs_pkg::REG_VERIFY_ONLY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      verify_only_r <= 1'b0;
    end else if (wr_en) begin
      verify_only_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == avcs_pkg::REG_VERIFY_ONLY) begin
      prdata[0] = verify_only_r;
    end
  end

  assign verify_only = verify_only_r;

endmodule

// File: sv/avcs_parser.sv
module avcs_parser #(
  parameter int COUNT_BITS = avcs_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  verify_only,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  in_ready,
  input  logic                  slot_free,
  output logic                  load,
  output avcs_pkg::avcs_burst_t burst
);

  typedef enum logic [3:0] {
    PH_HDR, PH_SPS_HI, PH_SPS_LO, PH_SPS_PAY, PH_PPS_CNT,
    PH_PPS_HI, PH_PPS_LO, PH_PPS_PAY, PH_DONE, PH_DRAIN
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [2:0]            hdr_idx_r, hdr_idx_nxt;
  logic [4:0]            sps_r, sps_nxt;
  logic [7:0]            pps_r, pps_nxt;
  logic [15:0]           pay_r, pay_nxt;
  logic [7:0]            len_hi_r, len_hi_nxt;
  logic [2:0]            fsize_r, fsize_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  err_r, err_nxt;

  logic                  accept;
  logic                  conv;
  logic                  emit_start;
  logic                  emit_pay;
  logic [7:0]            top_bits;
  logic [4:0]            sps_dec;
  logic [7:0]            pps_dec;
  logic [15:0]           new_len;
  logic [2:0]            inc;
  logic [COUNT_BITS:0]   cnt_sum;
  avcs_pkg::avcs_status_t st;

  assign in_ready = slot_free;
  assign accept   = in_valid && slot_free;
  assign conv     = !verify_only;
  assign top_bits = in_byte & avcs_pkg::RESERVED_MASK;
  assign sps_dec  = sps_r - 5'd1;
  assign pps_dec  = pps_r - 8'd1;
  assign new_len  = {len_hi_r, in_byte};

  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    sps_nxt     = sps_r;
    pps_nxt     = pps_r;
    pay_nxt     = pay_r;
    len_hi_nxt  = len_hi_r;
    fsize_nxt   = fsize_r;
    err_nxt     = err_r;
    emit_start  = 1'b0;
    emit_pay    = 1'b0;
    unique case (phase_r)
      PH_HDR: begin
        if (hdr_idx_r == 3'd0 && in_byte != avcs_pkg::RECORD_VERSION) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DRAIN;
        end else if (hdr_idx_r == avcs_pkg::HDR_LEN_IDX &&
                     top_bits != avcs_pkg::RESERVED_MASK && top_bits != 8'h00) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DRAIN;
        end else begin
          if (hdr_idx_r == avcs_pkg::HDR_LEN_IDX) begin
            fsize_nxt = {1'b0, in_byte[1:0] & avcs_pkg::LEN_SIZE_MASK[1:0]} + 3'd1;
          end
          if (hdr_idx_r == avcs_pkg::HDR_LAST_IDX) begin
            sps_nxt   = in_byte[4:0] & avcs_pkg::SPS_CNT_MASK[4:0];
            phase_nxt = (sps_nxt != 5'd0) ? PH_SPS_HI : PH_PPS_CNT;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 3'd1;
          end
        end
      end
      PH_SPS_HI: begin
        len_hi_nxt = in_byte;
        phase_nxt  = PH_SPS_LO;
      end
      PH_PPS_HI: begin
        len_hi_nxt = in_byte;
        phase_nxt  = PH_PPS_LO;
      end
      PH_SPS_LO: begin
        pay_nxt    = new_len;
        emit_start = conv;
        if (new_len == 16'd0) begin
          sps_nxt   = sps_dec;
          phase_nxt = (sps_dec != 5'd0) ? PH_SPS_HI : PH_PPS_CNT;
        end else begin
          phase_nxt = PH_SPS_PAY;
        end
      end
      PH_PPS_LO: begin
        pay_nxt    = new_len;
        emit_start = conv;
        if (new_len == 16'd0) begin
          pps_nxt   = pps_dec;
          phase_nxt = (pps_dec != 8'd0) ? PH_PPS_HI : PH_DONE;
        end else begin
          phase_nxt = PH_PPS_PAY;
        end
      end
      PH_SPS_PAY: begin
        emit_pay = conv;
        pay_nxt  = pay_r - 16'd1;
        if (pay_nxt == 16'd0) begin
          sps_nxt   = sps_dec;
          phase_nxt = (sps_dec != 5'd0) ? PH_SPS_HI : PH_PPS_CNT;
        end
      end
      PH_PPS_PAY: begin
        emit_pay = conv;
        pay_nxt  = pay_r - 16'd1;
        if (pay_nxt == 16'd0) begin
          pps_nxt   = pps_dec;
          phase_nxt = (pps_dec != 8'd0) ? PH_PPS_HI : PH_DONE;
        end
      end
      PH_PPS_CNT: begin
        pps_nxt   = in_byte;
        phase_nxt = (in_byte != 8'd0) ? PH_PPS_HI : PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // saturating emitted-byte count
  assign inc     = emit_start ? 3'd4 : (emit_pay ? 3'd1 : 3'd0);
  assign cnt_sum = {1'b0, cnt_r} + (COUNT_BITS+1)'(inc);
  assign cnt_nxt = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];

  always_comb begin
    priority if (err_nxt) begin
      st = avcs_pkg::ST_NOT_RECORD;
    end else if (phase_nxt == PH_DONE) begin
      st = avcs_pkg::ST_OK;
    end else if (phase_nxt == PH_HDR) begin
      st = avcs_pkg::ST_NOT_RECORD;
    end else begin
      st = avcs_pkg::ST_TRUNCATED;
    end
  end

  always_comb begin
    burst.start    = emit_start;
    burst.pay      = emit_pay;
    burst.pay_byte = in_byte;
    burst.fin      = in_last;
    burst.status   = st;
    burst.lfs      = (st == avcs_pkg::ST_OK && conv) ? fsize_nxt : 3'd0;
    burst.total    = (st == avcs_pkg::ST_OK) ? avcs_pkg::TOTAL_W'(cnt_nxt) : '0;
  end

  assign load = accept && (emit_start || emit_pay || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last)) begin
      phase_r   <= PH_HDR;
      hdr_idx_r <= '0;
      sps_r     <= '0;
      pps_r     <= '0;
      pay_r     <= '0;
      len_hi_r  <= '0;
      fsize_r   <= '0;
      cnt_r     <= '0;
      err_r     <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      sps_r     <= sps_nxt;
      pps_r     <= pps_nxt;
      pay_r     <= pay_nxt;
      len_hi_r  <= len_hi_nxt;
      fsize_r   <= fsize_nxt;
      cnt_r     <= cnt_nxt;
      err_r     <= err_nxt;
    end
  end

endmodule

// File: sv/avcs_emitter.sv
`include "avc_config_record_to_start_codes_top_defines.svh"

module avcs_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  avcs_pkg::avcs_burst_t burst,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  is_end,
  output logic [1:0]            status,
  output logic [2:0]            length_field_size,
  output logic [19:0]           total_size
);

  // slots 0..3 carry the start code, then payload, then end item
  localparam logic [2:0] SLOT_SC_LAST = 3'd3;
  localparam logic [2:0] SLOT_PAY     = 3'd4;
  localparam logic [2:0] SLOT_END     = 3'd5;

  avcs_pkg::avcs_burst_t burst_r;
  logic                  valid_r;
  logic [2:0]            slot_r, slot_nxt;
  logic [2:0]            first_slot;
  logic                  has_next;
  logic                  last_step;

  always_comb begin
    has_next = 1'b0;
    slot_nxt = slot_r;
    priority if (slot_r < SLOT_SC_LAST) begin
      has_next = 1'b1;
      slot_nxt = slot_r + 3'd1;
    end else if (slot_r == SLOT_SC_LAST && burst_r.pay) begin
      has_next = 1'b1;
      slot_nxt = SLOT_PAY;
    end else if (slot_r != SLOT_END && burst_r.fin) begin
      has_next = 1'b1;
      slot_nxt = SLOT_END;
    end
  end

  assign first_slot = burst.start ? 3'd0 : (burst.pay ? SLOT_PAY : SLOT_END);
  assign last_step  = !has_next;
  assign slot_free  = !valid_r || (out_ready && last_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      slot_r  <= first_slot;
    end else if (valid_r && out_ready) begin
      if (has_next) begin
        slot_r <= slot_nxt;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

  always_comb begin
    priority if (slot_r < SLOT_SC_LAST) begin
      out_byte = 8'h00;
    end else if (slot_r == SLOT_SC_LAST) begin
      out_byte = 8'h01;
    end else if (slot_r == SLOT_PAY) begin
      out_byte = burst_r.pay_byte;
    end else begin
      out_byte = 8'h00;
    end
  end

  assign out_valid         = valid_r;
  assign is_end            = (slot_r == SLOT_END);
  assign status            = is_end ? burst_r.status : 2'd0;
  assign length_field_size = is_end ? burst_r.lfs : 3'd0;
  assign total_size        = is_end ? burst_r.total : 20'd0;

  `AVCS_ASSERT(a_burst_holds, valid_r && !last_step |=> valid_r, "burst dropped mid-way")
  `AVCS_ASSERT(a_stall_holds_slot, valid_r && !out_ready |=> $stable(slot_r), "slot moved on stall")
  `AVCS_ASSERT(a_byte_items_clean, valid_r && !is_end |-> status == 2'd0 && total_size == 20'd0 && length_field_size == 3'd0, "status on byte item")
  `AVCS_ASSERT_ALWAYS(a_slot_range, valid_r |-> slot_r <= SLOT_END, "slot out of range")

endmodule

// File: sv/avc_config_record_to_start_codes_top.sv
// AVC configuration record to start-code converter.
// in_ch (sink): one record byte per transfer, in_last on the final byte.
// out_ch (source): stream bytes, then one end item (is_end) per record carrying
//   status, NAL length field size and saturating byte count.
// APB port: register 0 (verify_only) at address 0; 1 suppresses all byte output.
// Latency: a byte's first result appears the cycle after the byte is taken.
// Throughput: one input byte per cycle while out_ch.ready is high and each
//   byte yields at most one result (payload or skipped bytes). A byte closing a
//   length field yields the 4-byte start code; a final byte adds the end item,
//   so after such a byte in_ch.ready is low while the output register walks it.
// The next byte is taken in the same cycle that the burst's last result
//   transfers, so back-to-back streaming has no bubble.
// Stall: when out_ch.ready is low the current result holds and in_ch.ready
//   drops once the output register is occupied.
// Reset (rst_n, synchronous): empties the output register, returns the parser
//   to the header of a new record and clears verify_only.
// After each end item the parser restarts on the next byte.
module avc_config_record_to_start_codes_top #(
  parameter int COUNT_BITS = avcs_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  avcs_in_if.sink                       in_ch,
  avcs_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [avcs_pkg::ADDR_W-1:0]   paddr,
  input  logic [avcs_pkg::DATA_W-1:0]   pwdata,
  output logic [avcs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic                  verify_only;
  logic                  slot_free;
  logic                  load;
  avcs_pkg::avcs_burst_t burst;

  avcs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .verify_only (verify_only)
  );

  avcs_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .verify_only (verify_only),
    .in_valid    (in_ch.valid),
    .in_byte     (in_ch.in_byte),
    .in_last     (in_ch.in_last),
    .in_ready    (in_ch.ready),
    .slot_free   (slot_free),
    .load        (load),
    .burst       (burst)
  );

  avcs_emitter u_emitter (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .burst             (burst),
    .slot_free         (slot_free),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_byte          (out_ch.out_byte),
    .is_end            (out_ch.is_end),
    .status            (out_ch.status),
    .length_field_size (out_ch.length_field_size),
    .total_size        (out_ch.total_size)
  );

endmodule
